// ----- rtl/pcc_pkg.sv -----
// ----------------------------------------------------------------------------
// pcc_pkg
// Shared types, codes and constants of the pointer card controller.
// ----------------------------------------------------------------------------
package pcc_pkg;

    localparam int PCC_COORD_BITS = 16;
    localparam int MAX_RES        = 6;
    localparam int RES_CNT_W      = $clog2(MAX_RES + 1);
    localparam int RES_IDX_W      = $clog2(MAX_RES);

    typedef enum logic [1:0] {
        OP_BUS    = 2'd0,
        OP_SAMPLE = 2'd1,
        OP_VBL    = 2'd2,
        OP_POLL   = 2'd3
    } t_op;

    localparam logic [3:0] REG_MODE = 4'd2;
    localparam logic [3:0] REG_CMD  = 4'd3;

    localparam logic [7:0] CMD_CLAMP_X = 8'd0;
    localparam logic [7:0] CMD_CLAMP_Y = 8'd1;
    localparam logic [7:0] CMD_INIT    = 8'd2;
    localparam logic [7:0] CMD_SERVE   = 8'd3;
    localparam logic [7:0] CMD_READ    = 8'd4;
    localparam logic [7:0] CMD_CLEAR   = 8'd5;
    localparam logic [7:0] CMD_POS     = 8'd6;
    localparam logic [7:0] CMD_HOME    = 8'd7;

    localparam logic [10:0] ADDR_X_LO  = 11'h478;
    localparam logic [10:0] ADDR_X_HI  = 11'h578;
    localparam logic [10:0] ADDR_Y_LO  = 11'h4F8;
    localparam logic [10:0] ADDR_Y_HI  = 11'h5F8;
    localparam logic [10:0] ADDR_STAT  = 11'h778;
    localparam logic [10:0] ADDR_MODE  = 11'h7F8;

    localparam logic [7:0]  READ_VALUE = 8'hA0;
    localparam int          MAX_RESET  = 1023;

    typedef struct packed {
        t_op         opcode;
        logic [3:0]  reg_offset;
        logic [7:0]  data_byte;
        logic [15:0] clamp_first;
        logic [15:0] clamp_second;
        logic [15:0] hole_x;
        logic [15:0] hole_y;
        logic [15:0] sample_x;
        logic [15:0] sample_y;
        logic        button_down;
    } t_item;

    typedef struct packed {
        logic        mem_write;
        logic [10:0] mem_addr;
        logic [7:0]  mem_data;
        logic [7:0]  read_data;
        logic        irq_line;
        logic        last;
    } t_res;

    typedef struct packed {
        logic        wr;
        logic [10:0] addr;
        logic [7:0]  data;
    } t_ent;

    typedef struct packed {
        t_ent [MAX_RES-1:0]   ent;
        logic [RES_CNT_W-1:0] cnt;
        logic                 irq;
    } t_plan;

    function automatic t_ent mk_ent(logic [10:0] base, logic [2:0] slot, logic [7:0] data);
        t_ent e;
        e.wr   = 1'b1;
        e.addr = base + {8'd0, slot};
        e.data = data;
        return e;
    endfunction

endpackage

// ----- rtl/pcc_in_if.sv -----
// ----------------------------------------------------------------------------
// pcc_in_if
// Input item channel: valid/ready handshake with one input item.
// ----------------------------------------------------------------------------
interface pcc_in_if
    import pcc_pkg::*;
;
    logic  valid;
    logic  ready;
    t_item item;

    modport source (output valid, output item, input ready);
    modport sink   (input valid, input item, output ready);
endinterface

// ----- rtl/pcc_out_if.sv -----
// ----------------------------------------------------------------------------
// pcc_out_if
// Result item channel: valid/ready handshake with one result item.
// ----------------------------------------------------------------------------
interface pcc_out_if
    import pcc_pkg::*;
;
    logic valid;
    logic ready;
    t_res item;

    modport source (output valid, output item, input ready);
    modport sink   (input valid, input item, output ready);
endinterface

// ----- rtl/pcc_core.sv -----
// ----------------------------------------------------------------------------
// pcc_core
// Input register, card state and command decode; builds the result plan
// of one item in a single pass.
// ----------------------------------------------------------------------------
module pcc_core
    import pcc_pkg::*;
#(
    parameter int COORD_BITS = PCC_COORD_BITS
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic [2:0] i_slot,
    pcc_in_if.sink     i_in,
    input  logic       i_plan_ready,
    output logic       o_plan_valid,
    output t_plan      o_plan
);

    localparam int CB = COORD_BITS;
    localparam logic [CB-1:0] MAX_RST = CB'(MAX_RESET);

    logic          r_a_valid;
    t_item         r_a_item;
    logic          load;

    logic [3:0]    r_mode,    n_mode;
    logic [3:0]    r_irq,     n_irq;
    logic [CB-1:0] r_pos_x,   n_pos_x;
    logic [CB-1:0] r_pos_y,   n_pos_y;
    logic [CB-1:0] r_seen_x,  n_seen_x;
    logic [CB-1:0] r_seen_y,  n_seen_y;
    logic [CB-1:0] r_srv_x,   n_srv_x;
    logic [CB-1:0] r_srv_y,   n_srv_y;
    logic [CB-1:0] r_min_x,   n_min_x;
    logic [CB-1:0] r_min_y,   n_min_y;
    logic [CB-1:0] r_max_x,   n_max_x;
    logic [CB-1:0] r_max_y,   n_max_y;
    logic          r_btn_now, n_btn_now;
    logic          r_btn_bef, n_btn_bef;
    logic          r_pending, n_pending;
    logic          r_active,  n_active;

    logic [CB-1:0] cl_a, cl_b, cl_lo, cl_hi;
    logic [CB-1:0] hx, hy, cx_pos, cy_pos;
    logic [CB-1:0] smp_x, smp_y;
    logic [CB-1:0] cx, cy;
    logic [15:0]   cx16, cy16;
    logic          emit_xy;
    logic          moved;
    logic [7:0]    status;
    t_plan         plan;

    assign load         = r_a_valid && i_plan_ready;
    assign i_in.ready   = !r_a_valid || load;
    assign o_plan_valid = r_a_valid;
    assign o_plan       = plan;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (i_in.valid && i_in.ready) begin
            r_a_valid <= 1'b1;
        end else if (load) begin
            r_a_valid <= 1'b0;
        end
        if (i_in.valid && i_in.ready) begin
            r_a_item <= i_in.item;
        end
    end

    assign cl_a   = r_a_item.clamp_first[CB-1:0];
    assign cl_b   = r_a_item.clamp_second[CB-1:0];
    assign cl_lo  = (cl_a > cl_b) ? cl_b : cl_a;
    assign cl_hi  = (cl_a > cl_b) ? cl_a : cl_b;
    assign hx     = r_a_item.hole_x[CB-1:0];
    assign hy     = r_a_item.hole_y[CB-1:0];
    assign cx_pos = (hx < r_min_x) ? r_min_x : (hx > r_max_x) ? r_max_x : hx;
    assign cy_pos = (hy < r_min_y) ? r_min_y : (hy > r_max_y) ? r_max_y : hy;
    assign smp_x  = r_a_item.sample_x[CB-1:0];
    assign smp_y  = r_a_item.sample_y[CB-1:0];
    assign moved  = (r_pos_x != r_srv_x) || (r_pos_y != r_srv_y);
    assign status = {r_btn_now, 1'b0, moved, 4'b0000, r_btn_bef}
                  | {4'b0000, r_irq[3:1], 1'b0};
    assign cx16   = 16'(cx);
    assign cy16   = 16'(cy);

    always_comb begin
        n_mode    = r_mode;
        n_irq     = r_irq;
        n_pos_x   = r_pos_x;
        n_pos_y   = r_pos_y;
        n_seen_x  = r_seen_x;
        n_seen_y  = r_seen_y;
        n_srv_x   = r_srv_x;
        n_srv_y   = r_srv_y;
        n_min_x   = r_min_x;
        n_min_y   = r_min_y;
        n_max_x   = r_max_x;
        n_max_y   = r_max_y;
        n_btn_now = r_btn_now;
        n_btn_bef = r_btn_bef;
        n_pending = r_pending;
        n_active  = r_active;
        plan      = '0;
        plan.cnt  = RES_CNT_W'(1);
        emit_xy   = 1'b0;
        cx        = '0;
        cy        = '0;

        unique case (r_a_item.opcode)
            OP_BUS: begin
                unique if (r_a_item.reg_offset == REG_MODE) begin
                    n_mode      = r_a_item.data_byte[3:0];
                    plan.ent[0] = mk_ent(ADDR_MODE, i_slot,
                                         {4'b0000, r_a_item.data_byte[3:0]});
                end else if (r_a_item.reg_offset == REG_CMD) begin
                    unique case (r_a_item.data_byte)
                        CMD_CLAMP_X: begin
                            n_min_x = cl_lo;
                            n_max_x = cl_hi;
                        end
                        CMD_CLAMP_Y: begin
                            n_min_y = cl_lo;
                            n_max_y = cl_hi;
                        end
                        CMD_INIT: begin
                            n_mode    = '0;
                            n_irq     = '0;
                            n_pos_x   = '0;
                            n_pos_y   = '0;
                            n_seen_x  = '0;
                            n_seen_y  = '0;
                            n_srv_x   = '0;
                            n_srv_y   = '0;
                            n_min_x   = '0;
                            n_min_y   = '0;
                            n_max_x   = MAX_RST;
                            n_max_y   = MAX_RST;
                            n_btn_now = 1'b0;
                            n_btn_bef = 1'b0;
                            n_pending = 1'b0;
                            n_active  = 1'b0;
                            emit_xy   = 1'b1;
                            plan.ent[4] = mk_ent(ADDR_STAT, i_slot, 8'd0);
                            plan.ent[5] = mk_ent(ADDR_MODE, i_slot, 8'd0);
                            plan.cnt    = RES_CNT_W'(6);
                        end
                        CMD_SERVE: begin
                            if (moved) begin
                                n_srv_x = r_pos_x;
                                n_srv_y = r_pos_y;
                            end
                            plan.ent[0] = mk_ent(ADDR_STAT, i_slot, status);
                            n_irq     = '0;
                            n_active  = 1'b0;
                            n_pending = 1'b0;
                        end
                        CMD_READ: begin
                            if (moved) begin
                                n_srv_x = r_pos_x;
                                n_srv_y = r_pos_y;
                            end
                            n_btn_bef   = r_btn_now;
                            emit_xy     = 1'b1;
                            cx          = r_pos_x;
                            cy          = r_pos_y;
                            plan.ent[4] = mk_ent(ADDR_STAT, i_slot, status);
                            plan.cnt    = RES_CNT_W'(5);
                        end
                        CMD_CLEAR: begin
                            n_pos_x  = '0;
                            n_pos_y  = '0;
                            emit_xy  = 1'b1;
                            plan.cnt = RES_CNT_W'(4);
                        end
                        CMD_POS: begin
                            n_pos_x  = cx_pos;
                            n_pos_y  = cy_pos;
                            emit_xy  = 1'b1;
                            cx       = cx_pos;
                            cy       = cy_pos;
                            plan.cnt = RES_CNT_W'(4);
                        end
                        CMD_HOME: begin
                            n_pos_x  = r_min_x;
                            n_pos_y  = r_min_y;
                            emit_xy  = 1'b1;
                            cx       = r_min_x;
                            cy       = r_min_y;
                            plan.cnt = RES_CNT_W'(4);
                        end
                        default: begin
                        end
                    endcase
                end else begin
                end
            end
            OP_SAMPLE: begin
                if (r_mode[0]) begin
                    n_pos_x   = smp_x;
                    n_pos_y   = smp_y;
                    n_btn_now = r_a_item.button_down;
                    if (!r_pending && (r_a_item.button_down != r_btn_now) && r_mode[2]) begin
                        n_irq[2] = 1'b1;
                    end
                    if ((smp_x != r_seen_x) || (smp_y != r_seen_y)) begin
                        if (!r_pending && r_mode[1]) begin
                            n_irq[1] = 1'b1;
                        end
                        n_seen_x = smp_x;
                        n_seen_y = smp_y;
                    end
                    if (n_irq != r_irq) begin
                        n_pending = 1'b1;
                    end
                end
            end
            OP_VBL: begin
                if (!r_pending && r_mode[3] && !r_irq[3]) begin
                    n_pending = 1'b1;
                    n_irq[3]  = 1'b1;
                end
            end
            OP_POLL: begin
                if (r_pending) begin
                    n_active = 1'b1;
                end
            end
            default: begin
            end
        endcase

        if (emit_xy) begin
            plan.ent[0] = mk_ent(ADDR_X_LO, i_slot, cx16[7:0]);
            plan.ent[1] = mk_ent(ADDR_X_HI, i_slot, cx16[15:8]);
            plan.ent[2] = mk_ent(ADDR_Y_LO, i_slot, cy16[7:0]);
            plan.ent[3] = mk_ent(ADDR_Y_HI, i_slot, cy16[15:8]);
        end
        plan.irq = n_active;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= '0;
            r_irq     <= '0;
            r_pos_x   <= '0;
            r_pos_y   <= '0;
            r_seen_x  <= '0;
            r_seen_y  <= '0;
            r_srv_x   <= '0;
            r_srv_y   <= '0;
            r_min_x   <= '0;
            r_min_y   <= '0;
            r_max_x   <= MAX_RST;
            r_max_y   <= MAX_RST;
            r_btn_now <= 1'b0;
            r_btn_bef <= 1'b0;
            r_pending <= 1'b0;
            r_active  <= 1'b0;
        end else if (load) begin
            r_mode    <= n_mode;
            r_irq     <= n_irq;
            r_pos_x   <= n_pos_x;
            r_pos_y   <= n_pos_y;
            r_seen_x  <= n_seen_x;
            r_seen_y  <= n_seen_y;
            r_srv_x   <= n_srv_x;
            r_srv_y   <= n_srv_y;
            r_min_x   <= n_min_x;
            r_min_y   <= n_min_y;
            r_max_x   <= n_max_x;
            r_max_y   <= n_max_y;
            r_btn_now <= n_btn_now;
            r_btn_bef <= n_btn_bef;
            r_pending <= n_pending;
            r_active  <= n_active;
        end
    end

    a_active_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_active |-> r_pending)
        else $error("irq active without pending");

    a_pending_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pending |-> (r_irq != 4'd0))
        else $error("irq pending with no flag set");

    a_irq_bit0: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_irq[0])
        else $error("irq bit 0 set");

    a_state_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$past(load) && $past(i_rst_n) |-> $stable(r_mode) && $stable(r_pos_x))
        else $error("state changed without an item");

endmodule

// ----- rtl/pcc_emit.sv -----
// ----------------------------------------------------------------------------
// pcc_emit
// Result register: holds one item's plan and sends its results one per cycle while o_out is ready.
// ----------------------------------------------------------------------------
module pcc_emit
    import pcc_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_plan_valid,
    input  t_plan      i_plan,
    output logic       o_plan_ready,
    pcc_out_if.source  o_out
);

    logic                 r_valid;
    t_plan                r_plan;
    logic [RES_IDX_W-1:0] r_idx;
    logic                 take;
    logic                 is_last;
    logic                 load;
    t_ent                 cur;

    assign cur     = r_plan.ent[r_idx];
    assign is_last = (RES_CNT_W'(r_idx) + RES_CNT_W'(1)) == r_plan.cnt;
    assign take    = r_valid && o_out.ready;
    assign o_plan_ready = !r_valid || (take && is_last);
    assign load    = i_plan_valid && o_plan_ready;

    assign o_out.valid          = r_valid;
    assign o_out.item.mem_write = cur.wr;
    assign o_out.item.mem_addr  = cur.addr;
    assign o_out.item.mem_data  = cur.data;
    assign o_out.item.read_data = READ_VALUE;
    assign o_out.item.irq_line  = r_plan.irq;
    assign o_out.item.last      = is_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= '0;
        end else if (load) begin
            r_valid <= 1'b1;
            r_idx   <= '0;
        end else if (take && is_last) begin
            r_valid <= 1'b0;
        end else if (take) begin
            r_idx   <= r_idx + RES_IDX_W'(1);
        end
        if (load) begin
            r_plan <= i_plan;
        end
    end

    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> (r_plan.cnt != '0) && (RES_CNT_W'(r_idx) < r_plan.cnt))
        else $error("result index out of range");

    a_idx_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        take && !is_last |=> r_valid && (r_idx == $past(r_idx) + RES_IDX_W'(1)))
        else $error("result index did not advance");

    a_last_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        take && is_last && !i_plan_valid |=> !r_valid)
        else $error("valid held after last result");

endmodule

// ----- rtl/pointer_card_controller_top.sv -----
// ----------------------------------------------------------------------------
// pointer_card_controller_top
// Pointer interface card: bus commands, pointer samples, vertical-blank ticks
// and interrupt polls in; screen-hole writes, bus read data and irq level out.
//
//   port          dir   handshake        content
//   i_in          in    valid/ready      opcode, bus write, clamp/hole words,
//                                        pointer sample
//   o_out         out   valid/ready      memory write, read data, irq, last
//   i_cfg_we      in    write enable     slot number on i_cfg_wdata
//
// An item is registered, decoded in one pass, and its plan is loaded into the
// result register; the result register then sends 1 to 6 results, one per
// cycle while o_out is ready. Single-result items run one per cycle while
// o_out is ready. The result register loads the next plan as the last
// result of the current item is taken. Reset is synchronous and returns all
// card state (slot included) to its initial value.
// ----------------------------------------------------------------------------
module pointer_card_controller_top
    import pcc_pkg::*;
#(
    parameter int COORD_BITS = PCC_COORD_BITS
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [2:0] i_cfg_wdata,
    pcc_in_if.sink     i_in,
    pcc_out_if.source  o_out
);

    logic [2:0] r_slot;
    logic       plan_valid;
    logic       plan_ready;
    t_plan      plan;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot <= '0;
        end else if (i_cfg_we) begin
            r_slot <= i_cfg_wdata;
        end
    end

    pcc_core #(
        .COORD_BITS (COORD_BITS)
    ) u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_slot       (r_slot),
        .i_in         (i_in),
        .i_plan_ready (plan_ready),
        .o_plan_valid (plan_valid),
        .o_plan       (plan)
    );

    pcc_emit u_emit (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_plan_valid (plan_valid),
        .i_plan       (plan),
        .o_plan_ready (plan_ready),
        .o_out        (o_out)
    );

endmodule
